// ----- hdl/dhcl_pkg.sv -----
// Shared types and constants for the deduplicating host list.
`timescale 1ns / 1ps

package dhcl_pkg;

	localparam int IP_W    = 32;
	localparam int PORT_W  = 16;
	localparam int DRAW_W  = 16;
	localparam int COUNT_W = 7;
	localparam int ENTRY_W = IP_W + PORT_W;

	// Host list actions
	typedef enum logic [1:0] {
		ACT_ADD        = 2'd0,
		ACT_GET_FRONT  = 2'd1,
		ACT_GET_RANDOM = 2'd2,
		ACT_REMOVE     = 2'd3
	} action_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_PLAN,
		ST_MUL,
		ST_CLAMP,
		ST_GET_RD,
		ST_GET_LAT,
		ST_SH_CHK,
		ST_SH_RD,
		ST_SH_WR,
		ST_APPEND,
		ST_FIN
	} state_t;

	// Result word handed from the sequencer to the top level
	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] port;
	} result_t;

endpackage

// ----- hdl/dedup_host_cache_list_core.sv -----
// Top level of the deduplicating host list: limit register, sequencer and entry memory.
`timescale 1ns / 1ps

// Usage:
// A command word (action, host_ip, host_port, random_draw) is taken at a rising
// edge with start high and busy low. busy stays high while the word is worked on.
// Each word yields one result word: done is high for exactly one cycle with hit,
// out_ip, out_port and entry_count valid in that cycle. The receiver cannot stall.
// Sequence: add and remove scan the list, reading and then comparing each entry
// examined, then move entries, each shifted entry read and then written (the
// appended one only written); gets move entries the same way. The worst case is
// an add of a new host to a full list, as the entry memory reads one entry at a time.
// busy stays high while done is shown and drops in the next cycle, when the
// next word can be taken.
// max_entries is written through cfg_valid/cfg_ready; the user must write it only
// while idle, which the block itself does not enforce. cfg_ready is always high.
// A limit above CAPACITY acts as CAPACITY; a lowered limit trims the list on the next add.
// Reset (arst_n low) empties the list and sets max_entries to 64. The entry
// memory is not cleared; only entries below the held count are ever used.
module dedup_host_cache_list_core #(
	parameter int CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    action,
	input  logic [dhcl_pkg::IP_W-1:0]     host_ip,
	input  logic [dhcl_pkg::PORT_W-1:0]   host_port,
	input  logic [dhcl_pkg::DRAW_W-1:0]   random_draw,
	output logic                          done,
	output logic                          hit,
	output logic [dhcl_pkg::IP_W-1:0]     out_ip,
	output logic [dhcl_pkg::PORT_W-1:0]   out_port,
	output logic [dhcl_pkg::COUNT_W-1:0]  entry_count,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dhcl_pkg::COUNT_W-1:0]  cfg_data
);
	import dhcl_pkg::*;

	localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int LIMW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam logic [COUNT_W-1:0] MAX_RESET = 7'd64;

	logic [COUNT_W-1:0] max_q;
	logic [LIMW-1:0]    max_ext;
	logic [LIMW-1:0]    lim_ext;
	logic [LIMW-1:0]    cnt_ext;
	logic [CW-1:0]      limit;
	logic [CW-1:0]      count_w;
	result_t            result;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata;

	// Hold the limit register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_q <= cfg_data;
		end
	end

	// Clip the limit to capacity
	assign max_ext = LIMW'(max_q);
	assign lim_ext = (max_ext > LIMW'(CAPACITY)) ? LIMW'(CAPACITY) : max_ext;
	assign limit   = lim_ext[CW-1:0];

	dhcl_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (action_t'(action)),
		.host_ip     (host_ip),
		.host_port   (host_port),
		.random_draw (random_draw),
		.limit       (limit),
		.busy        (busy),
		.result      (result),
		.count_out   (count_w),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	dhcl_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Drive the result word
	assign cnt_ext     = LIMW'(count_w);
	assign done        = result.valid;
	assign hit         = result.hit;
	assign out_ip      = result.ip;
	assign out_port    = result.port;
	assign entry_count = cnt_ext[COUNT_W-1:0];

endmodule

// ----- hdl/dhcl_mem.sv -----
// Single-port-write, registered-read entry memory for the host list.
`timescale 1ns / 1ps

module dhcl_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [AW-1:0]                   waddr,
	input  logic [dhcl_pkg::ENTRY_W-1:0]    wdata,
	input  logic [AW-1:0]                   raddr,
	output logic [dhcl_pkg::ENTRY_W-1:0]    rdata
);
	import dhcl_pkg::*;

	logic [ENTRY_W-1:0] mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Register the read word
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/dhcl_ctrl.sv -----
// Sequencer for the host list: search, pick, shift and append over the entry memory.
`timescale 1ns / 1ps

module dhcl_ctrl #(
	parameter int CAPACITY = 64,
	parameter int AW       = 6,
	parameter int CW       = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  dhcl_pkg::action_t             action,
	input  logic [dhcl_pkg::IP_W-1:0]     host_ip,
	input  logic [dhcl_pkg::PORT_W-1:0]   host_port,
	input  logic [dhcl_pkg::DRAW_W-1:0]   random_draw,
	input  logic [CW-1:0]                 limit,
	output logic                          busy,
	output dhcl_pkg::result_t             result,
	output logic [CW-1:0]                 count_out,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output logic [dhcl_pkg::ENTRY_W-1:0]  mem_wdata,
	output logic [AW-1:0]                 mem_raddr,
	input  logic [dhcl_pkg::ENTRY_W-1:0]  mem_rdata
);
	import dhcl_pkg::*;

	localparam int NW = CW + 1;
	localparam int SW = CW + 2;
	localparam int PW = DRAW_W + CW;

	state_t               state_q, state_d;
	action_t              act_q;
	logic [ENTRY_W-1:0]   key_q;
	logic [DRAW_W-1:0]    draw_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        end_q;
	logic [CW-1:0]        i_q;
	logic [CW-1:0]        pos_q;
	logic [SW-1:0]        d_q;
	logic                 found_q;
	logic                 pend_q;
	logic                 usep_q;
	logic [ENTRY_W-1:0]   pd_q;
	logic                 hit_q;
	logic [ENTRY_W-1:0]   ret_q;

	logic [SW-1:0]        src;
	logic                 src_pend;
	logic                 match;
	logic [NW-1:0]        n_w;
	logic [NW-1:0]        lim_w;
	logic [NW-1:0]        drop_w;
	logic [NW-1:0]        keep_w;
	logic [PW-1:0]        prod;

	// Shift source, compare and trim arithmetic
	assign src      = SW'(i_q) + d_q;
	assign src_pend = pend_q && (src == SW'(count_q));
	assign match    = (mem_rdata == key_q);
	assign n_w      = NW'(count_q) + NW'(!found_q);
	assign lim_w    = NW'(limit);
	assign drop_w   = (n_w > lim_w) ? (n_w - lim_w) : '0;
	assign keep_w   = n_w - drop_w;
	assign prod     = PW'(draw_q) * PW'(count_q);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = i_q[AW-1:0];
		mem_wdata = usep_q ? pd_q : mem_rdata;
		mem_raddr = i_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (action) inside
						ACT_ADD, ACT_REMOVE: state_d = ST_SRCH_RD;
						ACT_GET_FRONT:       state_d = (count_q == '0) ? ST_FIN : ST_GET_RD;
						ACT_GET_RANDOM:      state_d = (count_q == '0) ? ST_FIN : ST_MUL;
						default:             state_d = ST_FIN;
					endcase
				end
			end
			ST_SRCH_RD: begin
				state_d = (i_q == count_q) ? ST_PLAN : ST_SRCH_CMP;
			end
			ST_SRCH_CMP: begin
				state_d = match ? ST_PLAN : ST_SRCH_RD;
			end
			ST_PLAN: begin
				if (act_q == ACT_ADD) begin
					if (drop_w != '0) begin
						state_d = ST_SH_CHK;
					end else begin
						state_d = found_q ? ST_FIN : ST_APPEND;
					end
				end else begin
					state_d = found_q ? ST_SH_CHK : ST_FIN;
				end
			end
			ST_MUL:     state_d = ST_CLAMP;
			ST_CLAMP:   state_d = ST_GET_RD;
			ST_GET_RD: begin
				mem_raddr = pos_q[AW-1:0];
				state_d   = ST_GET_LAT;
			end
			ST_GET_LAT: state_d = ST_SH_CHK;
			ST_SH_CHK: begin
				if (i_q >= end_q) begin
					state_d = ST_FIN;
				end else begin
					state_d = src_pend ? ST_SH_WR : ST_SH_RD;
				end
			end
			ST_SH_RD: begin
				mem_raddr = src[AW-1:0];
				state_d   = ST_SH_WR;
			end
			ST_SH_WR: begin
				mem_we  = 1'b1;
				state_d = ST_SH_CHK;
			end
			ST_APPEND: begin
				mem_we    = 1'b1;
				mem_waddr = count_q[AW-1:0];
				mem_wdata = pd_q;
				state_d   = ST_FIN;
			end
			ST_FIN:     state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Held count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == ST_FIN) begin
			count_q <= end_q;
		end
	end

	// Working registers of the current word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				act_q   <= action;
				key_q   <= {host_ip, host_port};
				pd_q    <= {host_ip, host_port};
				draw_q  <= random_draw;
				i_q     <= '0;
				pos_q   <= '0;
				d_q     <= SW'(1);
				found_q <= 1'b0;
				pend_q  <= 1'b0;
				usep_q  <= 1'b0;
				hit_q   <= 1'b0;
				ret_q   <= '0;
				end_q   <= count_q;
			end
			ST_SRCH_CMP: begin
				if (match) begin
					found_q <= 1'b1;
					pos_q   <= i_q;
				end else begin
					i_q <= i_q + CW'(1);
				end
			end
			ST_PLAN: begin
				if (act_q == ACT_ADD) begin
					hit_q  <= found_q;
					d_q    <= SW'(drop_w);
					end_q  <= keep_w[CW-1:0];
					pend_q <= !found_q;
					i_q    <= '0;
				end else if (found_q) begin
					hit_q  <= 1'b1;
					d_q    <= SW'(1);
					end_q  <= count_q - CW'(1);
					pend_q <= 1'b0;
					i_q    <= pos_q;
				end
			end
			ST_MUL: begin
				pos_q <= prod[PW-1:DRAW_W];
			end
			ST_CLAMP: begin
				if (pos_q >= count_q) begin
					pos_q <= count_q - CW'(1);
				end
			end
			ST_GET_LAT: begin
				hit_q  <= 1'b1;
				ret_q  <= mem_rdata;
				pd_q   <= mem_rdata;
				pend_q <= 1'b1;
				d_q    <= SW'(1);
				i_q    <= pos_q;
				end_q  <= count_q;
			end
			ST_SH_CHK: begin
				usep_q <= src_pend;
			end
			ST_SH_WR: begin
				i_q <= i_q + CW'(1);
			end
			default: begin
			end
		endcase
	end

	// Result word and status
	assign busy         = (state_q != ST_IDLE);
	assign result.valid = (state_q == ST_FIN);
	assign result.hit   = hit_q;
	assign result.ip    = ret_q[ENTRY_W-1:PORT_W];
	assign result.port  = ret_q[PORT_W-1:0];
	assign count_out    = end_q;

`ifndef SYNTH
	a_fin_single: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> (state_q == ST_IDLE))
		else $error("result strobe lasted more than one cycle");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(count_q) <= CAPACITY))
		else $error("held count above capacity");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (32'(mem_waddr) < CAPACITY))
		else $error("entry write beyond capacity");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && (state_q == ST_IDLE)) |=> busy)
		else $error("accepted word did not raise busy");

	a_plan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SH_CHK) |-> (32'(end_q) <= CAPACITY))
		else $error("shift end beyond capacity");
`endif

endmodule
